/* hw/rtl/balanced_multi_queue_store_top_defines.svh */
// assertion macros for the balanced multi-queue store
`ifndef BALANCED_MULTI_QUEUE_STORE_TOP_DEFINES_SVH
`define BALANCED_MULTI_QUEUE_STORE_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define BMQS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define BMQS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/bmqs_pkg.sv */
// shared constants and codes for the balanced multi-queue store
package bmqs_pkg;

	// default sizes
	localparam int NUM_QUEUES_DEF    = 4;
	localparam int SEGMENT_DEPTH_DEF = 10;

	// fixed field widths
	localparam int FUNC_W = 2;
	localparam int SEL_W  = 2;
	localparam int VAL_W  = 32;
	localparam int STAT_W = 2;
	localparam int CNT_W  = 4;

	// operation codes
	localparam logic [FUNC_W-1:0] FUNC_PUSH       = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_POP        = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_PUSH_SHORT = 2'd2;
	localparam logic [FUNC_W-1:0] FUNC_POP_LONG   = 2'd3;

	// status codes
	localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
	localparam logic [STAT_W-1:0] ST_OVERFLOW  = 2'd1;
	localparam logic [STAT_W-1:0] ST_UNDERFLOW = 2'd2;

endpackage

/* hw/rtl/bmqs_ram.sv */
// generic single-port synchronous ram with registered read
module bmqs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 40
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* hw/rtl/bmqs_pick.sv */
// shortest and longest queue selection, compare tree with lowest-index tie break
module bmqs_pick #(
	parameter int NUM_QUEUES = bmqs_pkg::NUM_QUEUES_DEF,
	parameter int CW         = 4
) (
	input  logic [NUM_QUEUES-1:0][CW-1:0]  occ,
	output logic [$clog2(NUM_QUEUES)-1:0]  short_idx,
	output logic [$clog2(NUM_QUEUES)-1:0]  long_idx
);

	localparam int LV  = $clog2(NUM_QUEUES);
	localparam int PAD = 1 << LV;

	logic [CW-1:0] mn_v [LV+1][PAD];
	logic [LV-1:0] mn_i [LV+1][PAD];
	logic [CW-1:0] mx_v [LV+1][PAD];
	logic [LV-1:0] mx_i [LV+1][PAD];

	// pairwise tree: the right leaf wins only when strictly better
	always_comb begin
		for (int l = 0; l <= LV; l++) begin
			for (int i = 0; i < PAD; i++) begin
				mn_v[l][i] = '0;
				mn_i[l][i] = '0;
				mx_v[l][i] = '0;
				mx_i[l][i] = '0;
			end
		end
		// leaves, padding never wins
		for (int i = 0; i < PAD; i++) begin
			if (i < NUM_QUEUES) begin
				mn_v[0][i] = occ[i];
				mx_v[0][i] = occ[i];
			end else begin
				mn_v[0][i] = '1;
				mx_v[0][i] = '0;
			end
			mn_i[0][i] = LV'(i);
			mx_i[0][i] = LV'(i);
		end
		for (int l = 0; l < LV; l++) begin
			for (int i = 0; i < (PAD >> (l + 1)); i++) begin
				if (mn_v[l][2*i+1] < mn_v[l][2*i]) begin
					mn_v[l+1][i] = mn_v[l][2*i+1];
					mn_i[l+1][i] = mn_i[l][2*i+1];
				end else begin
					mn_v[l+1][i] = mn_v[l][2*i];
					mn_i[l+1][i] = mn_i[l][2*i];
				end
				if (mx_v[l][2*i+1] > mx_v[l][2*i]) begin
					mx_v[l+1][i] = mx_v[l][2*i+1];
					mx_i[l+1][i] = mx_i[l][2*i+1];
				end else begin
					mx_v[l+1][i] = mx_v[l][2*i];
					mx_i[l+1][i] = mx_i[l][2*i];
				end
			end
		end
	end

	assign short_idx = mn_i[LV][0];
	assign long_idx  = mx_i[LV][0];

endmodule

/* hw/rtl/balanced_multi_queue_store_top.sv */
// Balanced multi-queue store: NUM_QUEUES linear FIFOs, each in a fixed segment
// of SEGMENT_DEPTH words of one shared single-port RAM. A request is taken on
// any clock edge with start high (busy stays low), one request per cycle; its
// result appears with done high in the next cycle, lined up with the
// registered RAM read. Results cannot be held off and must be taken in the
// cycle they are shown. Segment slots are written once and never reused, so a
// queue takes SEGMENT_DEPTH pushes in total. Ties on shortest or longest queue
// go to the lowest queue number. The RAM is undefined after reset and needs no
// clearing: only slots that were pushed are ever read.
module balanced_multi_queue_store_top #(
	parameter int NUM_QUEUES    = bmqs_pkg::NUM_QUEUES_DEF,
	parameter int SEGMENT_DEPTH = bmqs_pkg::SEGMENT_DEPTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [bmqs_pkg::FUNC_W-1:0]        func,
	input  logic [bmqs_pkg::SEL_W-1:0]         queue_select,
	input  logic signed [bmqs_pkg::VAL_W-1:0]  push_value,
	output logic                               done,
	output logic [bmqs_pkg::STAT_W-1:0]        status,
	output logic [1:0]                         queue_served,
	output logic signed [bmqs_pkg::VAL_W-1:0]  pop_value,
	output logic [bmqs_pkg::CNT_W-1:0]         queue_count
);

	localparam int QW    = $clog2(NUM_QUEUES);
	localparam int CW    = $clog2(SEGMENT_DEPTH + 1);
	localparam int DEPTH = NUM_QUEUES * SEGMENT_DEPTH;
	localparam int AW    = $clog2(DEPTH);

	logic [NUM_QUEUES-1:0][CW-1:0] push_cnt_q;
	logic [NUM_QUEUES-1:0][CW-1:0] pop_cnt_q;
	logic [NUM_QUEUES-1:0][CW-1:0] occ;

	logic [bmqs_pkg::SEL_W-1:0]    sel_wrap;
	logic [QW+bmqs_pkg::SEL_W-1:0] sel_ext;
	logic [QW-1:0]                 q_named;
	logic [QW-1:0]                 short_idx;
	logic [QW-1:0]                 long_idx;
	logic [QW-1:0]                 q;
	logic                          is_push;
	logic                          full;
	logic                          empty;
	logic                          accept;
	logic                          do_push;
	logic                          do_pop;
	logic [CW-1:0]                 ptr;
	logic [AW-1:0]                 addr;
	logic [bmqs_pkg::STAT_W-1:0]   status_d;
	logic [CW-1:0]                 occ_after;
	logic [bmqs_pkg::VAL_W-1:0]    rdata;

	logic                          valid_s1;
	logic                          pop_ok_s1;
	logic [bmqs_pkg::STAT_W-1:0]   status_s1;
	logic [QW-1:0]                 served_s1;
	logic [CW-1:0]                 count_s1;

	logic [QW+1:0]                 served_ext;
	logic [CW+bmqs_pkg::CNT_W-1:0] count_ext;

	// occupancy per queue
	always_comb begin
		for (int i = 0; i < NUM_QUEUES; i++) begin
			occ[i] = push_cnt_q[i] - pop_cnt_q[i];
		end
	end

	bmqs_pick #(
		.NUM_QUEUES (NUM_QUEUES),
		.CW         (CW)
	) u_pick (
		.occ       (occ),
		.short_idx (short_idx),
		.long_idx  (long_idx)
	);

	// named queue wraps modulo the queue count, one subtract suffices
	always_comb begin
		if (queue_select >= NUM_QUEUES) begin
			sel_wrap = queue_select - bmqs_pkg::SEL_W'(NUM_QUEUES);
		end else begin
			sel_wrap = queue_select;
		end
		sel_ext = {QW'(0), sel_wrap};
		q_named = sel_ext[QW-1:0];
	end

	// operation decode and queue choice
	always_comb begin
		is_push = 1'b0;
		q       = q_named;
		unique case (func)
			bmqs_pkg::FUNC_PUSH: begin
				is_push = 1'b1;
				q       = q_named;
			end
			bmqs_pkg::FUNC_POP: begin
				is_push = 1'b0;
				q       = q_named;
			end
			bmqs_pkg::FUNC_PUSH_SHORT: begin
				is_push = 1'b1;
				q       = short_idx;
			end
			bmqs_pkg::FUNC_POP_LONG: begin
				is_push = 1'b0;
				q       = long_idx;
			end
			default: begin
				is_push = 1'b0;
				q       = q_named;
			end
		endcase
	end

	// full and empty tests, status
	assign full    = push_cnt_q[q] == CW'(SEGMENT_DEPTH);
	assign empty   = pop_cnt_q[q] == push_cnt_q[q];
	assign accept  = start && !busy;
	assign do_push = accept && is_push && !full;
	assign do_pop  = accept && !is_push && !empty;

	always_comb begin
		if (is_push) begin
			status_d = full ? bmqs_pkg::ST_OVERFLOW : bmqs_pkg::ST_OK;
		end else begin
			status_d = empty ? bmqs_pkg::ST_UNDERFLOW : bmqs_pkg::ST_OK;
		end
	end

	// occupancy of the served queue after this request
	always_comb begin
		if (do_push) begin
			occ_after = occ[q] + CW'(1);
		end else if (do_pop) begin
			occ_after = occ[q] - CW'(1);
		end else begin
			occ_after = occ[q];
		end
	end

	// slot address: segment base plus head or tail pointer
	assign ptr  = is_push ? push_cnt_q[q] : pop_cnt_q[q];
	assign addr = AW'(q) * AW'(SEGMENT_DEPTH) + AW'(ptr);

	bmqs_ram #(
		.WIDTH (bmqs_pkg::VAL_W),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (do_push),
		.re    (do_pop),
		.addr  (addr),
		.wdata (push_value),
		.rdata (rdata)
	);

	// push and pop counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push_cnt_q <= '0;
			pop_cnt_q  <= '0;
		end else begin
			if (do_push) begin
				push_cnt_q[q] <= push_cnt_q[q] + CW'(1);
			end
			if (do_pop) begin
				pop_cnt_q[q] <= pop_cnt_q[q] + CW'(1);
			end
		end
	end

	// result stage, lines up with the ram read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			pop_ok_s1 <= 1'b0;
		end else begin
			valid_s1  <= accept;
			pop_ok_s1 <= do_pop;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1 <= status_d;
			served_s1 <= q;
			count_s1  <= occ_after;
		end
	end

	// result ports
	assign served_ext   = {2'b00, served_s1};
	assign count_ext    = {bmqs_pkg::CNT_W'(0), count_s1};
	assign busy         = 1'b0;
	assign done         = valid_s1;
	assign status       = status_s1;
	assign queue_served = served_ext[1:0];
	assign queue_count  = count_ext[bmqs_pkg::CNT_W-1:0];
	assign pop_value    = pop_ok_s1 ? $signed(rdata) : '0;

endmodule

/* hw/rtl/bmqs_checker.sv */
// port-level checks for the balanced multi-queue store, bound to the top level
`include "balanced_multi_queue_store_top_defines.svh"

module bmqs_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               start,
	input logic                               busy,
	input logic                               done,
	input logic [bmqs_pkg::STAT_W-1:0]        status,
	input logic signed [bmqs_pkg::VAL_W-1:0]  pop_value,
	input logic [bmqs_pkg::CNT_W-1:0]         queue_count
);

	logic failed_result;
	logic underflow_result;

	// result flags
	assign failed_result    = done && status != bmqs_pkg::ST_OK;
	assign underflow_result = done && status == bmqs_pkg::ST_UNDERFLOW;

	// every request gets its result in the next cycle
	`BMQS_ASSERT_NEXT(a_result_follows, start && !busy, done, "request without result")

	// no result without a request
	`BMQS_ASSERT_NEXT(a_no_stray_result, !(start && !busy), !done, "result without request")

	// failed requests return no data
	`BMQS_ASSERT_NOW(a_fail_no_data, failed_result, pop_value == '0, "data on failed request")

	// an underflow leaves the served queue empty
	`BMQS_ASSERT_NOW(a_underflow_empty, underflow_result, queue_count == '0, "underflow not empty")

endmodule

bind balanced_multi_queue_store_top bmqs_checker u_checker (.*);
